// ----- rtl/iwd_pkg.sv -----
package iwd_pkg;

    // addressing mode codes
    localparam logic [3:0] MD_NONE = 4'd0;
    localparam logic [3:0] MD_REG  = 4'd1;
    localparam logic [3:0] MD_IDX  = 4'd2;
    localparam logic [3:0] MD_SYM  = 4'd3;
    localparam logic [3:0] MD_ABS  = 4'd4;
    localparam logic [3:0] MD_IND  = 4'd5;
    localparam logic [3:0] MD_AUTO = 4'd6;
    localparam logic [3:0] MD_IMM  = 4'd7;
    localparam logic [3:0] MD_JMP  = 4'd8;

    // operation codes
    localparam logic [4:0] OP_SWPB = 5'd1;
    localparam logic [4:0] OP_SXT  = 5'd3;
    localparam logic [4:0] OP_CALL = 5'd5;
    localparam logic [4:0] OP_RETI = 5'd6;
    localparam logic [4:0] OP_BAD1 = 5'd7;
    localparam logic [4:0] OP_MOV  = 5'd7;
    localparam logic [4:0] OP_DBL0 = 5'd3;
    localparam logic [4:0] OP_JMP0 = 5'd19;
    localparam logic [4:0] OP_RET  = 5'd27;
    localparam logic [4:0] OP_BR   = 5'd28;
    localparam logic [4:0] OP_NOP  = 5'd29;
    localparam logic [4:0] OP_POP  = 5'd30;
    localparam logic [4:0] OP_CLR  = 5'd31;

    // register numbers with special meaning
    localparam logic [3:0] RN_PC = 4'd0;
    localparam logic [3:0] RN_SP = 4'd1;
    localparam logic [3:0] RN_SR = 4'd2;
    localparam logic [3:0] RN_CG = 4'd3;

    // instruction lengths in bytes
    localparam logic [2:0] LEN_ONE   = 3'd2;
    localparam logic [2:0] LEN_TWO   = 3'd4;
    localparam logic [2:0] LEN_THREE = 3'd6;

    typedef struct packed {
        logic [3:0]  mode;
        logic [3:0]  rnum;
        logic [15:0] val;
        logic        ext;
    } t_opnd;

    // word state carried between the pipeline stages
    typedef struct packed {
        logic        ok;
        logic [4:0]  op;
        logic        bw;
        logic [1:0]  cnt;
        t_opnd       src;
        t_opnd       dst;
        logic [15:0] w1;
        logic [15:0] w2;
        logic [1:0]  avail;
        logic [2:0]  nbytes;
    } t_dec;

    typedef struct packed {
        logic [2:0]  consumed_bytes;
        logic [4:0]  operation;
        logic        byte_size;
        logic [1:0]  operand_count;
        logic [3:0]  src_addr_mode;
        logic [3:0]  src_reg;
        logic [15:0] src_value;
        logic [3:0]  dst_addr_mode;
        logic [3:0]  dst_reg;
        logic [15:0] dst_value;
    } t_result;

endpackage

// ----- rtl/iwd_in_if.sv -----
interface iwd_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic [15:0] third_word;
    logic [1:0]  words_available;

    modport source (
        output valid, first_word, second_word, third_word, words_available,
        input  ready
    );
    modport sink (
        input  valid, first_word, second_word, third_word, words_available,
        output ready
    );
endinterface

// ----- rtl/iwd_out_if.sv -----
interface iwd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  consumed_bytes;
    logic [4:0]  operation;
    logic        byte_size;
    logic [1:0]  operand_count;
    logic [3:0]  src_addr_mode;
    logic [3:0]  src_reg;
    logic [15:0] src_value;
    logic [3:0]  dst_addr_mode;
    logic [3:0]  dst_reg;
    logic [15:0] dst_value;

    modport source (
        output valid, consumed_bytes, operation, byte_size, operand_count,
               src_addr_mode, src_reg, src_value, dst_addr_mode, dst_reg, dst_value,
        input  ready
    );
    modport sink (
        input  valid, consumed_bytes, operation, byte_size, operand_count,
               src_addr_mode, src_reg, src_value, dst_addr_mode, dst_reg, dst_value,
        output ready
    );
endinterface

// ----- rtl/iwd_classify.sv -----
module iwd_classify (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [15:0]   i_first_word,
    input  logic [15:0]   i_second_word,
    input  logic [15:0]   i_third_word,
    input  logic [1:0]    i_words_available,
    output logic          o_valid,
    input  logic          i_ready,
    output iwd_pkg::t_dec o_word
);
    import iwd_pkg::*;

    // source operand decode, constant generators included
    function automatic t_opnd src_dec(input logic [1:0] as, input logic [3:0] r);
        t_opnd o;
        o = '0;
        case (as)
            2'd0: begin
                if (r == RN_CG) begin o.mode = MD_IMM; end
                else begin o.mode = MD_REG; o.rnum = r; end
            end
            2'd1: begin
                if (r == RN_PC) begin o.mode = MD_SYM; o.ext = 1'b1; end
                else if (r == RN_SR) begin o.mode = MD_ABS; o.ext = 1'b1; end
                else if (r == RN_CG) begin o.mode = MD_IMM; o.val = 16'd1; end
                else begin o.mode = MD_IDX; o.rnum = r; o.ext = 1'b1; end
            end
            2'd2: begin
                if (r == RN_SR) begin o.mode = MD_IMM; o.val = 16'd4; end
                else if (r == RN_CG) begin o.mode = MD_IMM; o.val = 16'd2; end
                else begin o.mode = MD_IND; o.rnum = r; end
            end
            default: begin
                if (r == RN_PC) begin o.mode = MD_IMM; o.ext = 1'b1; end
                else if (r == RN_SR) begin o.mode = MD_IMM; o.val = 16'd8; end
                else if (r == RN_CG) begin o.mode = MD_IMM; o.val = 16'hffff; end
                else begin o.mode = MD_AUTO; o.rnum = r; end
            end
        endcase
        return o;
    endfunction

    // destination operand decode
    function automatic t_opnd dst_dec(input logic ad, input logic [3:0] r);
        t_opnd o;
        o = '0;
        if (!ad) begin o.mode = MD_REG; o.rnum = r; end
        else if (r == RN_PC) begin o.mode = MD_SYM; o.ext = 1'b1; end
        else if (r == RN_SR) begin o.mode = MD_ABS; o.ext = 1'b1; end
        else begin o.mode = MD_IDX; o.rnum = r; o.ext = 1'b1; end
        return o;
    endfunction

    logic        r_valid;
    t_dec        r_word;
    t_dec        n_word;
    logic [15:0] w0;
    logic [4:0]  sel;
    logic [15:0] off;

    assign w0  = i_first_word;
    assign sel = {2'b00, w0[9:7]};
    assign off = {{6{w0[9]}}, w0[9:0]};

    // classify the format and split the first word into fields
    always_comb begin
        n_word        = '0;
        n_word.ok     = 1'b1;
        n_word.nbytes = LEN_ONE;
        n_word.w1     = i_second_word;
        n_word.w2     = i_third_word;
        n_word.avail  = i_words_available;
        if (i_words_available == 2'd0) begin
            n_word.ok = 1'b0;
        end else if (w0[15:11] == 5'b00010) begin
            n_word.bw = w0[6];
            n_word.op = sel;
            if (sel == OP_BAD1) begin
                n_word.ok = 1'b0;
            end else if ((sel == OP_SWPB || sel == OP_SXT || sel == OP_CALL) && w0[6]) begin
                n_word.ok = 1'b0;
            end else if (sel == OP_RETI && (w0[6] || w0[5:4] != 2'd0 || w0[3:0] != 4'd0)) begin
                n_word.ok = 1'b0;
            end
            if (n_word.ok && sel != OP_RETI) begin
                n_word.cnt = 2'd1;
                n_word.src = src_dec(w0[5:4], w0[3:0]);
            end
        end else if (w0[15:12] >= 4'd4) begin
            n_word.op  = {1'b0, w0[15:12]} + OP_DBL0;
            n_word.bw  = w0[6];
            n_word.cnt = 2'd2;
            n_word.src = src_dec(w0[5:4], w0[11:8]);
            n_word.dst = dst_dec(w0[7], w0[3:0]);
        end else if (w0[15:13] == 3'b001) begin
            n_word.op       = {2'b00, w0[12:10]} + OP_JMP0;
            n_word.cnt      = 2'd1;
            n_word.src.mode = MD_JMP;
            n_word.src.val  = {off[14:0], 1'b0} + 16'd2;
        end else begin
            n_word.ok = 1'b0;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // advance when the next stage has room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end
endmodule

// ----- rtl/iwd_operand.sv -----
module iwd_operand (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  iwd_pkg::t_dec i_word,
    output logic          o_valid,
    input  logic          i_ready,
    output iwd_pkg::t_dec o_word
);
    import iwd_pkg::*;

    logic r_valid;
    t_dec r_word;
    t_dec n_word;

    // take extension words in order and check there are enough of them
    always_comb begin
        n_word = i_word;
        if (n_word.ok && n_word.src.ext) begin
            if (n_word.avail < 2'd2) begin
                n_word.ok = 1'b0;
            end else begin
                n_word.src.val = n_word.w1;
                n_word.nbytes  = LEN_TWO;
            end
        end
        if (n_word.ok && n_word.dst.ext) begin
            if (n_word.nbytes == LEN_ONE) begin
                if (n_word.avail < 2'd2) begin
                    n_word.ok = 1'b0;
                end else begin
                    n_word.dst.val = n_word.w1;
                    n_word.nbytes  = LEN_TWO;
                end
            end else begin
                if (n_word.avail != 2'd3) begin
                    n_word.ok = 1'b0;
                end else begin
                    n_word.dst.val = n_word.w2;
                    n_word.nbytes  = LEN_THREE;
                end
            end
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end
endmodule

// ----- rtl/iwd_rewrite.sv -----
module iwd_rewrite (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  iwd_pkg::t_dec    i_word,
    output logic             o_valid,
    input  logic             i_ready,
    output iwd_pkg::t_result o_result
);
    import iwd_pkg::*;

    logic    r_valid;
    t_result r_result;
    t_result n_result;
    t_dec    d;
    logic    sp_pop;

    assign sp_pop = (i_word.src.mode == MD_AUTO) && (i_word.src.rnum == RN_SP);

    // rewrite emulated MOV forms, then blank the word if it is invalid
    always_comb begin
        d = i_word;
        if (d.op == OP_MOV) begin
            if (d.dst.mode == MD_REG && d.dst.rnum == RN_PC) begin
                if (sp_pop) begin
                    d.op = OP_RET; d.cnt = 2'd0; d.src = '0; d.dst = '0;
                end else begin
                    d.op = OP_BR; d.cnt = 2'd1; d.dst = '0;
                end
            end else if (d.dst.mode == MD_REG && d.dst.rnum == RN_CG) begin
                d.op = OP_NOP; d.cnt = 2'd0; d.src = '0; d.dst = '0;
            end else if (sp_pop) begin
                d.op = OP_POP; d.cnt = 2'd1; d.src = d.dst; d.dst = '0;
            end else if (d.src.mode == MD_IMM && d.src.val == 16'd0) begin
                d.op = OP_CLR; d.cnt = 2'd1; d.src = d.dst; d.dst = '0;
            end
        end
        n_result = '0;
        if (d.ok) begin
            n_result.consumed_bytes = d.nbytes;
            n_result.operation      = d.op;
            n_result.byte_size      = d.bw;
            n_result.operand_count  = d.cnt;
            n_result.src_addr_mode  = d.src.mode;
            n_result.src_reg        = d.src.rnum;
            n_result.src_value      = d.src.val;
            n_result.dst_addr_mode  = d.dst.mode;
            n_result.dst_reg        = d.dst.rnum;
            n_result.dst_value      = d.dst.val;
        end
    end

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // output register: hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= n_result;
        end
    end
endmodule

// ----- rtl/instruction_word_decoder_core.sv -----
// Decodes one instruction of a sixteen-bit microcontroller per word: the first
// instruction word plus up to two extension words in, operation, size, operand
// modes, registers and values plus length in bytes out (length 0 for an invalid
// or short instruction). A new word can be taken every clock cycle while input
// ready is high; a word passes through the three register stages (classify,
// extension-word fetch, emulated-form rewrite and output register) on its way out.
// Each stage advances on its own when the stage after it has room, so input ready
// drops only when all three stages are full and the output is stalled. Reset is
// synchronous and active low and empties the pipeline.
module instruction_word_decoder_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iwd_in_if.sink    i_word_in,
    iwd_out_if.source o_word_out
);
    import iwd_pkg::*;

    logic    s1_valid;
    logic    s1_ready;
    t_dec    s1_word;
    logic    s2_valid;
    logic    s2_ready;
    t_dec    s2_word;
    t_result res;

    iwd_classify u_classify (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_word_in.valid),
        .o_ready           (i_word_in.ready),
        .i_first_word      (i_word_in.first_word),
        .i_second_word     (i_word_in.second_word),
        .i_third_word      (i_word_in.third_word),
        .i_words_available (i_word_in.words_available),
        .o_valid           (s1_valid),
        .i_ready           (s1_ready),
        .o_word            (s1_word)
    );

    iwd_operand u_operand (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_word  (s1_word),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_word  (s2_word)
    );

    iwd_rewrite u_rewrite (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s2_valid),
        .o_ready  (s2_ready),
        .i_word   (s2_word),
        .o_valid  (o_word_out.valid),
        .i_ready  (o_word_out.ready),
        .o_result (res)
    );

    // unpack the result onto the output channel
    assign o_word_out.consumed_bytes = res.consumed_bytes;
    assign o_word_out.operation      = res.operation;
    assign o_word_out.byte_size      = res.byte_size;
    assign o_word_out.operand_count  = res.operand_count;
    assign o_word_out.src_addr_mode  = res.src_addr_mode;
    assign o_word_out.src_reg        = res.src_reg;
    assign o_word_out.src_value      = res.src_value;
    assign o_word_out.dst_addr_mode  = res.dst_addr_mode;
    assign o_word_out.dst_reg        = res.dst_reg;
    assign o_word_out.dst_value      = res.dst_value;
endmodule

// ----- rtl/iwd_checker.sv -----
module iwd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [2:0]  i_consumed_bytes,
    input logic [4:0]  i_operation,
    input logic [1:0]  i_operand_count,
    input logic [3:0]  i_src_addr_mode,
    input logic [3:0]  i_dst_addr_mode,
    input logic [15:0] i_src_value
);
    import iwd_pkg::*;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid after reset");

    // a stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_operation)
            && $stable(i_consumed_bytes) && $stable(i_src_value))
        else $error("stalled word changed or dropped");

    // an invalid word carries no decode at all
    a_invalid_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_consumed_bytes == 3'd0 |-> i_operation == 5'd0
            && i_operand_count == 2'd0 && i_src_addr_mode == MD_NONE
            && i_dst_addr_mode == MD_NONE && i_src_value == 16'd0)
        else $error("invalid word with decoded fields");

    // jumps are one word with a single operand
    a_jump_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_src_addr_mode == MD_JMP |-> i_consumed_bytes == LEN_ONE
            && i_operand_count == 2'd1 && i_dst_addr_mode == MD_NONE)
        else $error("malformed jump decode");

    // operandless forms leave both modes empty
    a_no_operand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_consumed_bytes != 3'd0 && i_operand_count == 2'd0
            |-> i_src_addr_mode == MD_NONE && i_dst_addr_mode == MD_NONE)
        else $error("operand mode set on operandless word");
endmodule

bind instruction_word_decoder_core iwd_checker u_iwd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_word_out.valid),
    .i_ready          (o_word_out.ready),
    .i_consumed_bytes (o_word_out.consumed_bytes),
    .i_operation      (o_word_out.operation),
    .i_operand_count  (o_word_out.operand_count),
    .i_src_addr_mode  (o_word_out.src_addr_mode),
    .i_dst_addr_mode  (o_word_out.dst_addr_mode),
    .i_src_value      (o_word_out.src_value)
);
